>>> hdl/atmpm_pkg.sv
// Shared constants, register indexes and types for the four-track mixer and peak meter.
// Used by every module of the block; depends on nothing.
package atmpm_pkg;

  localparam int NUM_TRACKS  = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int LEVEL_BITS  = SAMPLE_BITS - 1;
  localparam int GAIN_BITS   = 16;
  localparam int GAIN_FRAC   = 14;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int SUM_W       = PROD_W + $clog2(NUM_TRACKS);
  localparam int CFG_IDX_W   = 3;

  localparam logic [GAIN_BITS-1:0]  GAIN_MAX   = GAIN_BITS'(32768);
  localparam logic [GAIN_BITS-1:0]  GAIN_UNITY = GAIN_BITS'(16384);
  localparam int                    GAIN_HALF  = 8192;
  localparam logic [15:0]           DECAY_MUL  = 16'd57672;
  localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = {LEVEL_BITS{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN0 = 3'd0,
    REG_GAIN1 = 3'd1,
    REG_GAIN2 = 3'd2,
    REG_GAIN3 = 3'd3,
    REG_MUTE  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic adv;
    logic last;
    logic present;
    logic mute;
  } trk_ctl_t;

endpackage

>>> hdl/atmpm_track.sv
// One track lane: gained product for the mix, running raw peak and held meter level.
// Depends on atmpm_pkg.
module atmpm_track import atmpm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  trk_ctl_t                      ctl,
  input  logic [GAIN_BITS-1:0]          gain,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [PROD_W-1:0]      prod_r,
  output logic [LEVEL_BITS-1:0]         level_r
);

  logic [GAIN_BITS-1:0]            gain_eff;
  logic [SAMPLE_BITS-1:0]          abs_v;
  logic [SAMPLE_BITS-1:0]          raw_r;
  logic [SAMPLE_BITS-1:0]          raw_nxt;
  logic [LEVEL_BITS-1:0]           held_r;
  logic [LEVEL_BITS-1:0]           held_upd;
  logic signed [SAMPLE_BITS:0]     s_x;
  logic signed [GAIN_BITS:0]       g_x;
  logic signed [SAMPLE_BITS+GAIN_BITS+1:0] p_full;
  logic signed [PROD_W-1:0]        prod_nxt;
  logic [SAMPLE_BITS+GAIN_BITS-1:0] t_prod;
  logic [SAMPLE_BITS+GAIN_BITS:0]  t_round;
  logic [SAMPLE_BITS+GAIN_BITS-GAIN_FRAC:0] t_shift;
  logic [LEVEL_BITS-1:0]           target;
  logic [LEVEL_BITS+15:0]          d_prod;
  logic [LEVEL_BITS-1:0]           decayed;

  always_comb begin
    gain_eff = (gain > GAIN_MAX) ? GAIN_MAX : gain;
    abs_v    = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    raw_nxt  = (ctl.present && (abs_v > raw_r)) ? abs_v : raw_r;

    s_x      = {sample[SAMPLE_BITS-1], sample};
    g_x      = {1'b0, gain_eff};
    p_full   = s_x * g_x;
    prod_nxt = (ctl.present && !ctl.mute) ? p_full[PROD_W-1:0] : '0;

    t_prod   = raw_nxt * gain_eff;
    t_round  = {1'b0, t_prod} + (SAMPLE_BITS+GAIN_BITS+1)'(GAIN_HALF);
    t_shift  = t_round[SAMPLE_BITS+GAIN_BITS:GAIN_FRAC];
    if (ctl.mute) begin
      target = '0;
    end else if (t_shift > {{(SAMPLE_BITS+GAIN_BITS-GAIN_FRAC+1-LEVEL_BITS){1'b0}}, LEVEL_FULL})
    begin
      target = LEVEL_FULL;
    end else begin
      target = t_shift[LEVEL_BITS-1:0];
    end

    d_prod   = held_r * DECAY_MUL;
    decayed  = d_prod[LEVEL_BITS+15:16];
    held_upd = (target >= held_r) ? target : decayed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r  <= '0;
      held_r <= '0;
    end else if (ctl.adv) begin
      if (ctl.last) begin
        raw_r  <= '0;
        held_r <= held_upd;
      end else begin
        raw_r  <= raw_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      prod_r  <= prod_nxt;
      level_r <= ctl.last ? held_upd : '0;
    end
  end

endmodule

>>> hdl/audio_track_mixer_peak_meter.sv
// Top level of the four-track mixer with peak meter: ports, gain and mute registers,
// input, product and result registers and the final sum. Depends on atmpm_pkg, atmpm_track.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------------
//   in      | in_valid/in_ready  | in_sample_track0..3, in_sample_valid, in_last_of_frame
//   out     | out_valid/out_ready| out_mixed_sample, out_frame_done, out_peak_track0..3
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A beat passes three registers: input register, product register (the per-track
// multipliers and meter update) and result register (the four-way sum), and its result
// shows on the out channel from the result register. One beat can enter in every cycle
// while out_ready stays high; the meter state changes as a beat leaves the input
// register. Reset is synchronous and sets all gains to unity, clears mute and the meters.
// A stall at the result register backs up through the stages to in_ready.
module audio_track_mixer_peak_meter import atmpm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_track0,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_track1,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_track2,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_track3,
  input  logic [NUM_TRACKS-1:0]         in_sample_valid,
  input  logic                          in_last_of_frame,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_mixed_sample,
  output logic                          out_frame_done,
  output logic [LEVEL_BITS-1:0]         out_peak_track0,
  output logic [LEVEL_BITS-1:0]         out_peak_track1,
  output logic [LEVEL_BITS-1:0]         out_peak_track2,
  output logic [LEVEL_BITS-1:0]         out_peak_track3,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [GAIN_BITS-1:0]          cfg_data
);

  localparam logic signed [SUM_W-1:0] MIX_MAX = SUM_W'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [SUM_W-1:0] MIX_MIN = -SUM_W'(2**(SAMPLE_BITS-1));

  logic [GAIN_BITS-1:0]          gain_r [NUM_TRACKS];
  logic [NUM_TRACKS-1:0]         mute_r;

  logic                          s1_valid_r;
  logic                          s2_valid_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] sample_r [NUM_TRACKS];
  logic [NUM_TRACKS-1:0]         present_r;
  logic                          last_r;
  logic                          last2_r;

  logic                          in_acc;
  logic                          s2_go;
  logic                          out_ld;

  trk_ctl_t                      ctl [NUM_TRACKS];
  logic signed [PROD_W-1:0]      prod [NUM_TRACKS];
  logic [LEVEL_BITS-1:0]         level [NUM_TRACKS];

  logic signed [SUM_W-1:0]       sum;
  logic signed [SUM_W-1:0]       acc;
  logic signed [SUM_W-1:0]       acc_sh;
  logic signed [SAMPLE_BITS-1:0] mix_nxt;

  logic signed [SAMPLE_BITS-1:0] mixed_r;
  logic                          done_r;
  logic [LEVEL_BITS-1:0]         peak_r [NUM_TRACKS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < NUM_TRACKS; t++) begin
        gain_r[t] <= GAIN_UNITY;
      end
      mute_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN0: gain_r[0] <= cfg_data;
        REG_GAIN1: gain_r[1] <= cfg_data;
        REG_GAIN2: gain_r[2] <= cfg_data;
        REG_GAIN3: gain_r[3] <= cfg_data;
        REG_MUTE:  mute_r    <= cfg_data[NUM_TRACKS-1:0];
        default:   mute_r    <= mute_r;
      endcase
    end
  end

  assign out_ld   = s2_valid_r && (!out_valid_r || out_ready);
  assign s2_go    = s1_valid_r && (!s2_valid_r || out_ld);
  assign in_ready = !s1_valid_r || s2_go;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s2_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_go) begin
        s2_valid_r <= 1'b1;
      end else if (out_ld) begin
        s2_valid_r <= 1'b0;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r[0] <= in_sample_track0;
      sample_r[1] <= in_sample_track1;
      sample_r[2] <= in_sample_track2;
      sample_r[3] <= in_sample_track3;
      present_r   <= in_sample_valid;
      last_r      <= in_last_of_frame;
    end
    if (s2_go) begin
      last2_r <= last_r;
    end
  end

  for (genvar t = 0; t < NUM_TRACKS; t++) begin : g_trk
    assign ctl[t] = '{adv: s2_go, last: last_r, present: present_r[t], mute: mute_r[t]};

    atmpm_track u_trk (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl[t]),
      .gain    (gain_r[t]),
      .sample  (sample_r[t]),
      .prod_r  (prod[t]),
      .level_r (level[t])
    );
  end

  always_comb begin
    sum = '0;
    for (int t = 0; t < NUM_TRACKS; t++) begin
      sum = sum + {{(SUM_W-PROD_W){prod[t][PROD_W-1]}}, prod[t]};
    end
    acc    = sum + SUM_W'(GAIN_HALF);
    acc_sh = acc >>> GAIN_FRAC;
    if (acc_sh > MIX_MAX) begin
      mix_nxt = MIX_MAX[SAMPLE_BITS-1:0];
    end else if (acc_sh < MIX_MIN) begin
      mix_nxt = MIX_MIN[SAMPLE_BITS-1:0];
    end else begin
      mix_nxt = acc_sh[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      mixed_r <= mix_nxt;
      done_r  <= last2_r;
      for (int t = 0; t < NUM_TRACKS; t++) begin
        peak_r[t] <= level[t];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mixed_sample = mixed_r;
  assign out_frame_done   = done_r;
  assign out_peak_track0  = peak_r[0];
  assign out_peak_track1  = peak_r[1];
  assign out_peak_track2  = peak_r[2];
  assign out_peak_track3  = peak_r[3];

endmodule

>>> hdl/atmpm_checker.sv
// Port-level checker for the mixer and peak meter, with its bind to the top level.
// Depends on atmpm_pkg and audio_track_mixer_peak_meter.
module atmpm_checker import atmpm_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_frame_done,
  input logic [LEVEL_BITS-1:0]         out_peak_track0,
  input logic [LEVEL_BITS-1:0]         out_peak_track1,
  input logic [LEVEL_BITS-1:0]         out_peak_track2,
  input logic [LEVEL_BITS-1:0]         out_peak_track3
);

  logic [2:0] count_r;
  logic [2:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (in_valid && in_ready && !(out_valid && out_ready)) begin
      count_nxt = count_r + 3'd1;
    end else if (!(in_valid && in_ready) && out_valid && out_ready) begin
      count_nxt = count_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result beat dropped while stalled.");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> count_r != 3'd0)
    else $error("Result beat shown with no input beat in flight.");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'd3)
    else $error("More beats in flight than pipeline stages.");

  a_idle_peaks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |->
      out_peak_track0 == '0 && out_peak_track1 == '0 &&
      out_peak_track2 == '0 && out_peak_track3 == '0)
    else $error("Meter levels shown outside a frame end.");

endmodule

bind audio_track_mixer_peak_meter atmpm_checker u_atmpm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_frame_done  (out_frame_done),
  .out_peak_track0 (out_peak_track0),
  .out_peak_track1 (out_peak_track1),
  .out_peak_track2 (out_peak_track2),
  .out_peak_track3 (out_peak_track3)
);
